>>> rtl/sha1md_pkg.sv
package sha1md_pkg;

    typedef logic [31:0] t_word;

    // working variables a..e, also used for the chaining value H0..H4
    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
        t_word e;
    } t_vars;

    // sequencer to message schedule window
    typedef struct packed {
        logic       push;      // shift one message byte in
        logic       step;      // advance the schedule by one round
        logic [7:0] data;      // byte to shift in
    } t_sched_ctrl;

    localparam t_word K_R00 = 32'h5A827999;
    localparam t_word K_R20 = 32'h6ED9EBA1;
    localparam t_word K_R40 = 32'h8F1BBCDC;
    localparam t_word K_R60 = 32'hCA62C1D6;

    localparam t_vars IV_VARS = '{
        a: 32'h67452301,
        b: 32'hEFCDAB89,
        c: 32'h98BADCFE,
        d: 32'h10325476,
        e: 32'hC3D2E1F0
    };

    localparam logic [7:0] PAD_BYTE       = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS  = 6'd56;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [6:0] ROUND_LAST     = 7'd79;
    localparam logic [2:0] LEN_BYTE_LAST  = 3'd7;
    localparam logic [2:0] WORD_IDX_LAST  = 3'd4;

    localparam logic [6:0] ROUND_STAGE1 = 7'd20;
    localparam logic [6:0] ROUND_STAGE2 = 7'd40;
    localparam logic [6:0] ROUND_STAGE3 = 7'd60;

endpackage

>>> rtl/sha1_message_digest.sv
// SHA-1 hasher taking one message byte per input transaction (tdata), with tuser
// flagging a valid byte and tlast ending the message. Each byte is accepted, then
// shifted into the block window; each full 64-byte block then holds the input
// for 80 rounds through the single shared round unit and a final step that
// folds the result into the chaining value. At tlast the block is padded, one
// byte per cycle outside compressions (0x80, zeros, 64-bit length), which may
// cost a second compression, and the five digest words leave on the output
// stream, word 0 first, tuser giving the word index and tlast marking word 4.
// The hasher then returns to its initial values. No input is taken from tlast
// until the last digest word has been loaded into the output register.
module sha1_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last_word
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_PUSH  = 5'b00010,
        S_ROUND = 5'b00100,
        S_ADD   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    // what the next byte push is, or where to go once a compression ends
    typedef enum logic [5:0] {
        PH_IDLE = 6'b000001,
        PH_DATA = 6'b000010,
        PH_ONE  = 6'b000100,
        PH_ZERO = 6'b001000,
        PH_LEN  = 6'b010000,
        PH_OUT  = 6'b100000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;

    logic [7:0]  r_data;
    logic        r_eom;
    logic [63:0] r_bitlen;
    logic [5:0]  r_count;
    logic [5:0]  n_count;
    logic [2:0]  r_len_idx;
    logic [6:0]  r_round;
    logic [2:0]  r_widx;

    sha1md_pkg::t_vars r_h;
    sha1md_pkg::t_vars r_vars;
    sha1md_pkg::t_vars round_out;
    sha1md_pkg::t_word sched_w;
    sha1md_pkg::t_sched_ctrl sched_ctrl;

    logic [7:0]  len_byte;
    logic [7:0]  push_byte;
    logic [31:0] out_word;
    logic        s_accept;
    logic        out_load;

    logic        r_m_valid;
    logic [31:0] r_m_data;
    logic [2:0]  r_m_idx;
    logic        r_m_last;

    sha1md_lenmux u_lenmux (
        .i_len  (r_bitlen),
        .i_idx  (r_len_idx),
        .o_byte (len_byte)
    );

    sha1md_sched u_sched (
        .i_clk  (i_clk),
        .i_ctrl (sched_ctrl),
        .o_w    (sched_w)
    );

    sha1md_round u_round (
        .i_vars  (r_vars),
        .i_w     (sched_w),
        .i_round (r_round),
        .o_vars  (round_out)
    );

    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign out_load      = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);
    assign n_count       = r_count + 6'd1;

    always_comb begin
        case (r_phase)
            PH_DATA: push_byte = r_data;
            PH_ONE:  push_byte = sha1md_pkg::PAD_BYTE;
            PH_LEN:  push_byte = len_byte;
            default: push_byte = 8'h00;
        endcase
    end

    always_comb begin
        sched_ctrl.push = (r_state == S_PUSH);
        sched_ctrl.step = (r_state == S_ROUND);
        sched_ctrl.data = push_byte;
    end

    // phase that follows the current push
    always_comb begin
        case (r_phase)
            PH_DATA: n_phase = r_eom ? PH_ONE : PH_IDLE;
            PH_ONE,
            PH_ZERO: n_phase = (n_count == sha1md_pkg::LEN_FIELD_POS) ? PH_LEN : PH_ZERO;
            PH_LEN:  n_phase = (r_len_idx == sha1md_pkg::LEN_BYTE_LAST) ? PH_OUT : PH_LEN;
            default: n_phase = PH_IDLE;
        endcase
    end

    function automatic t_state resume(input t_phase ph);
        case (ph)
            PH_IDLE: resume = S_IDLE;
            PH_OUT:  resume = S_OUT;
            default: resume = S_PUSH;
        endcase
    endfunction

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (s_axis_tuser || s_axis_tlast) begin
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (r_count == sha1md_pkg::BLOCK_LAST_POS) begin
                    n_state = S_ROUND;
                end else begin
                    n_state = resume(n_phase);
                end
            end
            S_ROUND: begin
                if (r_round == sha1md_pkg::ROUND_LAST) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_state = resume(r_phase);
            end
            S_OUT: begin
                if (out_load && r_widx == sha1md_pkg::WORD_IDX_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (r_widx)
            3'd0:    out_word = r_h.a;
            3'd1:    out_word = r_h.b;
            3'd2:    out_word = r_h.c;
            3'd3:    out_word = r_h.d;
            3'd4:    out_word = r_h.e;
            default: out_word = r_h.e;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_IDLE;
            r_eom     <= 1'b0;
            r_bitlen  <= 64'd0;
            r_count   <= 6'd0;
            r_len_idx <= 3'd0;
            r_round   <= 7'd0;
            r_widx    <= 3'd0;
            r_h       <= sha1md_pkg::IV_VARS;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_data  <= s_axis_tdata;
                        r_eom   <= s_axis_tlast;
                        r_phase <= s_axis_tuser ? PH_DATA : PH_ONE;
                    end
                end
                S_PUSH: begin
                    r_count <= n_count;
                    r_phase <= n_phase;
                    if (r_phase == PH_DATA) begin
                        r_bitlen <= r_bitlen + 64'd8;
                    end
                    if (r_phase == PH_LEN) begin
                        r_len_idx <= r_len_idx + 3'd1;
                    end
                    if (r_count == sha1md_pkg::BLOCK_LAST_POS) begin
                        r_vars  <= r_h;
                        r_round <= 7'd0;
                    end
                end
                S_ROUND: begin
                    r_vars <= round_out;
                    if (r_round == sha1md_pkg::ROUND_LAST) begin
                        r_round <= 7'd0;
                    end else begin
                        r_round <= r_round + 7'd1;
                    end
                end
                S_ADD: begin
                    r_h.a <= r_h.a + r_vars.a;
                    r_h.b <= r_h.b + r_vars.b;
                    r_h.c <= r_h.c + r_vars.c;
                    r_h.d <= r_h.d + r_vars.d;
                    r_h.e <= r_h.e + r_vars.e;
                end
                S_OUT: begin
                    if (out_load) begin
                        if (r_widx == sha1md_pkg::WORD_IDX_LAST) begin
                            r_widx   <= 3'd0;
                            r_h      <= sha1md_pkg::IV_VARS;
                            r_bitlen <= 64'd0;
                            r_phase  <= PH_IDLE;
                        end else begin
                            r_widx <= r_widx + 3'd1;
                        end
                    end
                end
                default: ;
            endcase

            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_data <= out_word;
            r_m_idx  <= r_widx;
            r_m_last <= (r_widx == sha1md_pkg::WORD_IDX_LAST);
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_idx;
    assign m_axis_tlast  = r_m_last;

    // compression only starts on a block boundary
    a_round_on_boundary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_count == 6'd0))
        else $error("compression running with a partial block");

    a_round_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_ROUND) |-> (r_round == 7'd0))
        else $error("round counter not cleared outside compression");

    a_last_word_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == sha1md_pkg::WORD_IDX_LAST)))
        else $error("tlast does not match final digest word index");

    a_eom_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && s_axis_tlast) |=> !s_axis_tready)
        else $error("input taken while finishing a message");

endmodule

>>> rtl/sha1md_round.sv
module sha1md_round (
    input  sha1md_pkg::t_vars i_vars,
    input  sha1md_pkg::t_word i_w,
    input  logic [6:0]        i_round,
    output sha1md_pkg::t_vars o_vars
);

    sha1md_pkg::t_word f_val;
    sha1md_pkg::t_word k_val;
    sha1md_pkg::t_word tmp;

    always_comb begin
        if (i_round < sha1md_pkg::ROUND_STAGE1) begin
            f_val = (i_vars.b & i_vars.c) ^ (~i_vars.b & i_vars.d);
            k_val = sha1md_pkg::K_R00;
        end else if (i_round < sha1md_pkg::ROUND_STAGE2) begin
            f_val = i_vars.b ^ i_vars.c ^ i_vars.d;
            k_val = sha1md_pkg::K_R20;
        end else if (i_round < sha1md_pkg::ROUND_STAGE3) begin
            f_val = (i_vars.b & i_vars.c) ^ (i_vars.b & i_vars.d) ^ (i_vars.c & i_vars.d);
            k_val = sha1md_pkg::K_R40;
        end else begin
            f_val = i_vars.b ^ i_vars.c ^ i_vars.d;
            k_val = sha1md_pkg::K_R60;
        end
    end

    assign tmp = {i_vars.a[26:0], i_vars.a[31:27]} + f_val + i_vars.e + k_val + i_w;

    assign o_vars.a = tmp;
    assign o_vars.b = i_vars.a;
    assign o_vars.c = {i_vars.b[1:0], i_vars.b[31:2]};
    assign o_vars.d = i_vars.c;
    assign o_vars.e = i_vars.d;

endmodule

>>> rtl/sha1md_sched.sv
module sha1md_sched (
    input  logic                    i_clk,
    input  sha1md_pkg::t_sched_ctrl i_ctrl,
    output sha1md_pkg::t_word       o_w
);

    // window holds W[t]..W[t+15]; bytes enter at the low end of the last word
    sha1md_pkg::t_word r_win [16];
    sha1md_pkg::t_word w_mix;

    assign w_mix = r_win[13] ^ r_win[8] ^ r_win[2] ^ r_win[0];

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= {r_win[i][23:0], r_win[i+1][31:24]};
            end
            r_win[15] <= {r_win[15][23:0], i_ctrl.data};
        end else if (i_ctrl.step) begin
            for (int i = 0; i < 15; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[15] <= {w_mix[30:0], w_mix[31]};
        end
    end

    assign o_w = r_win[0];

endmodule

>>> rtl/sha1md_top_dummy_guard.sv
module sha1md_lenmux (
    input  logic [63:0] i_len,
    input  logic [2:0]  i_idx,
    output logic [7:0]  o_byte
);

    // big-endian length field, most significant byte first
    always_comb begin
        case (i_idx)
            3'd0:    o_byte = i_len[63:56];
            3'd1:    o_byte = i_len[55:48];
            3'd2:    o_byte = i_len[47:40];
            3'd3:    o_byte = i_len[39:32];
            3'd4:    o_byte = i_len[31:24];
            3'd5:    o_byte = i_len[23:16];
            3'd6:    o_byte = i_len[15:8];
            3'd7:    o_byte = i_len[7:0];
            default: o_byte = 8'h00;
        endcase
    end

endmodule

>>> test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        sha1md_pkg::t_word word;
        logic [2:0]        index;
        logic              last;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
    logic        s_axis_tuser = 1'b0;    // [0] has_byte
    logic        s_axis_tlast = 1'b0;    // end_of_message
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [2:0]  m_axis_tuser;           // [2:0] word_index
    logic        m_axis_tlast;           // last_word

    sha1_message_digest dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    sha1md_pkg::t_word chain_h [5];
    sha1md_pkg::t_word blk_w [16];
    logic [63:0]       msg_bits;
    int unsigned       blk_fill;

    t_digest_beat pending_digest [$];
    int           fail_count = 0;
    int           send_idle_pct = 34;
    int           recv_idle_pct = 60;
    int           items_sent = 0;

    function automatic void load_iv();
        chain_h[0] = sha1md_pkg::IV_VARS.a;
        chain_h[1] = sha1md_pkg::IV_VARS.b;
        chain_h[2] = sha1md_pkg::IV_VARS.c;
        chain_h[3] = sha1md_pkg::IV_VARS.d;
        chain_h[4] = sha1md_pkg::IV_VARS.e;
        msg_bits = '0;
        blk_fill = 0;
    endfunction

    function automatic void fold_block();
        sha1md_pkg::t_word a, b, c, d, e, f, k, w, tmp;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++) begin
            if (r >= 16) begin
                w = blk_w[(r - 3) & 15] ^ blk_w[(r - 8) & 15]
                  ^ blk_w[(r - 14) & 15] ^ blk_w[r & 15];
                blk_w[r & 15] = {w[30:0], w[31]};
            end
            w = blk_w[r & 15];
            if (r < 20) begin
                f = (b & c) ^ (~b & d);
                k = sha1md_pkg::K_R00;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_R20;
            end else if (r < 60) begin
                f = (b & c) ^ (b & d) ^ (c & d);
                k = sha1md_pkg::K_R40;
            end else begin
                f = b ^ c ^ d;
                k = sha1md_pkg::K_R60;
            end
            tmp = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = tmp;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // big-endian byte placement into the block words
    function automatic void load_byte(input logic [7:0] value);
        int unsigned pos;
        int unsigned shift;
        pos = blk_fill;
        shift = 24 - 8 * (pos % 4);
        if (pos % 4 == 0)
            blk_w[pos >> 2] = '0;
        blk_w[pos >> 2] |= sha1md_pkg::t_word'(value) << shift;
        pos++;
        if (pos == 64) begin
            blk_fill = 0;
            fold_block();
        end else begin
            blk_fill = pos;
        end
    endfunction

    function automatic void predict_digest(input logic [7:0] data, input logic has,
                                           input logic eom);
        logic [63:0]  len;
        t_digest_beat beat;
        if (has) begin
            load_byte(data);
            msg_bits += 64'd8;
        end
        if (eom) begin
            len = msg_bits;
            load_byte(sha1md_pkg::PAD_BYTE);
            while (blk_fill != 56)
                load_byte(8'h00);
            for (int i = 7; i >= 0; i--)
                load_byte(len[8 * i +: 8]);
            for (int i = 0; i < 5; i++) begin
                beat.word = chain_h[i];
                beat.index = 3'(i);
                beat.last = (i == 4);
                pending_digest.push_back(beat);
            end
            load_iv();
        end
    endfunction

    // receive side: random backpressure and result check
    always @(posedge i_clk) begin
        t_digest_beat exp_beat;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_digest.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected digest transaction: %h idx %0d last %0b",
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
            end else begin
                exp_beat = pending_digest.pop_front();
                if (m_axis_tdata !== exp_beat.word || m_axis_tuser !== exp_beat.index
                        || m_axis_tlast !== exp_beat.last) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("digest mismatch: exp %h idx %0d last %0b, got %h idx %0d last %0b",
                                 exp_beat.word, exp_beat.index, exp_beat.last,
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_item(input logic [7:0] data, input logic has, input logic eom);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= has;
        s_axis_tlast <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_digest(data, has, eom);
        if (has || eom)
            items_sent++;
    endtask

    // sender holds off until every digest word has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge i_clk);
    endtask

    // random bytes; noise inserts ignored items, sometimes the final item is empty
    task automatic send_message(input int len, input bit noisy);
        bit empty_final;
        empty_final = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(99) < 15)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, !empty_final && (i == len - 1));
        end
        if (empty_final)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    task automatic test_empty_message();
        send_item(8'hFF, 1'b0, 1'b1);
    endtask

    task automatic test_ignored_items();
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);
    endtask

    task automatic test_abc();
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
    endtask

    // high bytes must not sign-extend into the neighbouring byte lanes
    task automatic test_byte_extremes();
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h3C, 1'b0, 1'b1);
    endtask

    task automatic test_random_phase(input int snd_pct, input int rcv_pct,
                                     input int boundary_len);
        int start_items;
        int msgs;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        start_items = items_sent;
        msgs = 0;
        send_message($urandom_range(12), 1'b1);
        send_message(boundary_len, 1'b0);
        msgs = 2;
        while (items_sent - start_items < boundary_len + 8 || msgs < 3) begin
            send_message($urandom_range(12), 1'b1);
            msgs++;
        end
        wait_drained();
    endtask

    initial begin
        for (int i = 0; i < 16; i++)
            blk_w[i] = '0;
        load_iv();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_message();
        test_ignored_items();
        test_abc();
        test_byte_extremes();
        wait_drained();

        // 64 fills a whole block before the padding starts
        test_random_phase(34, 60, 64);
        test_random_phase(60, 34, 0);
        test_random_phase(0, 0, 0);

        s_axis_tvalid <= 1'b0;
        while (pending_digest.size() != 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending_digest.size() == 0)
            $display("sha1_message_digest regression: pass");
        else
            $display("sha1_message_digest regression: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("sha1_message_digest regression: fail");
        $finish;
    end

endmodule
